FILE: rtl/core/ted_pkg.sv
// Shared types and constants for the text encoding detector.
`timescale 1ns / 1ps

package ted_pkg;

	// Encoding codes reported on the result channel
	localparam logic [2:0] CODE_UTF8    = 3'd0;
	localparam logic [2:0] CODE_UTF16LE = 3'd1;
	localparam logic [2:0] CODE_UTF16BE = 3'd2;
	localparam logic [2:0] CODE_GBK     = 3'd3;
	localparam logic [2:0] CODE_SYSTEM  = 3'd4;

	// Byte order marks
	localparam logic [7:0] BOM8_B0  = 8'hEF;
	localparam logic [7:0] BOM8_B1  = 8'hBB;
	localparam logic [7:0] BOM8_B2  = 8'hBF;
	localparam logic [7:0] BOM16_FF = 8'hFF;
	localparam logic [7:0] BOM16_FE = 8'hFE;

	// GBK byte ranges
	localparam logic [7:0] GBK_LEAD_LO  = 8'h81;
	localparam logic [7:0] GBK_LEAD_HI  = 8'hFE;
	localparam logic [7:0] GBK_TRAIL_LO = 8'h40;
	localparam logic [7:0] GBK_TRAIL_HI = 8'hFE;
	localparam logic [7:0] ASCII_MAX    = 8'h7F;

	// Configuration register
	localparam logic [6:0] SHARE_RESET   = 7'd30;
	localparam logic [6:0] PERCENT_SCALE = 7'd100;

	// Per-file verdict flags handed from the scanner to the decision stages
	typedef struct packed {
		logic bom_utf8;
		logic bom_le;
		logic bom_be;
		logic utf8_ok;
		logic gbk_ok;
	} ted_flags_t;

endpackage

FILE: rtl/core/ted_scan.sv
// Byte scanner: per-file BOM capture, UTF-8 and GBK structure checks, counters.
`timescale 1ns / 1ps

module ted_scan import ted_pkg::*; #(
	parameter int MAX_BYTES = 4096,
	localparam int CW = $clog2(MAX_BYTES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	output ted_flags_t    flags,
	output logic [CW-1:0] dbl_count,
	output logic [CW-1:0] tot_count
);

	logic [CW-1:0] bytes_q, bytes_n;
	logic [23:0]   lead_q, lead_n;
	logic [1:0]    pend_q, pend_n;
	logic          u8_bad_q, u8_bad_n;
	logic          await_q, await_n;
	logic          gbk_bad_q, gbk_bad_n;
	logic [CW-1:0] dbl_q, dbl_n;
	logic [CW-1:0] tot_q, tot_n;
	logic          examine;

	assign examine = bytes_q < CW'(MAX_BYTES);

	// Fold the incoming word into the per-file state
	always_comb begin
		bytes_n   = bytes_q;
		lead_n    = lead_q;
		pend_n    = pend_q;
		u8_bad_n  = u8_bad_q;
		await_n   = await_q;
		gbk_bad_n = gbk_bad_q;
		dbl_n     = dbl_q;
		tot_n     = tot_q;
		if (examine) begin
			bytes_n = bytes_q + CW'(1);
			if (bytes_q == CW'(0)) lead_n[23:16] = data_byte;
			if (bytes_q == CW'(1)) lead_n[15:8]  = data_byte;
			if (bytes_q == CW'(2)) lead_n[7:0]   = data_byte;

			// UTF-8 structure
			if (!u8_bad_q) begin
				if (pend_q == 2'd0) begin
					if (data_byte[7] == 1'b0) begin
						pend_n = 2'd0;
					end else if (data_byte[7:5] == 3'b110) begin
						pend_n = 2'd1;
					end else if (data_byte[7:4] == 4'b1110) begin
						pend_n = 2'd2;
					end else if (data_byte[7:3] == 5'b11110) begin
						pend_n = 2'd3;
					end else begin
						u8_bad_n = 1'b1;
					end
				end else if (data_byte[7:6] != 2'b10) begin
					u8_bad_n = 1'b1;
				end else begin
					pend_n = pend_q - 2'd1;
				end
			end

			// GBK lead/trail pairs
			if (!gbk_bad_q) begin
				if (await_q) begin
					if (data_byte >= GBK_TRAIL_LO && data_byte <= GBK_TRAIL_HI &&
							data_byte != ASCII_MAX) begin
						dbl_n   = dbl_q + CW'(1);
						tot_n   = tot_q + CW'(1);
						await_n = 1'b0;
					end else begin
						gbk_bad_n = 1'b1;
					end
				end else if (data_byte <= ASCII_MAX) begin
					tot_n = tot_q + CW'(1);
				end else if (data_byte >= GBK_LEAD_LO && data_byte <= GBK_LEAD_HI) begin
					await_n = 1'b1;
				end else begin
					gbk_bad_n = 1'b1;
				end
			end
		end
	end

	// Verdict flags as they stand after this word
	always_comb begin
		flags.bom_utf8 = bytes_n >= CW'(3) && lead_n[23:16] == BOM8_B0 &&
			lead_n[15:8] == BOM8_B1 && lead_n[7:0] == BOM8_B2;
		flags.bom_le   = bytes_n >= CW'(2) && lead_n[23:16] == BOM16_FF &&
			lead_n[15:8] == BOM16_FE;
		flags.bom_be   = bytes_n >= CW'(2) && lead_n[23:16] == BOM16_FE &&
			lead_n[15:8] == BOM16_FF;
		flags.utf8_ok  = !u8_bad_n && pend_n == 2'd0;
		flags.gbk_ok   = !gbk_bad_n && !await_n && tot_n != CW'(0);
	end

	assign dbl_count = dbl_n;
	assign tot_count = tot_n;

	// Advance on each accepted word; clear after the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q   <= '0;
			lead_q    <= '0;
			pend_q    <= '0;
			u8_bad_q  <= 1'b0;
			await_q   <= 1'b0;
			gbk_bad_q <= 1'b0;
			dbl_q     <= '0;
			tot_q     <= '0;
		end else if (accept) begin
			if (last_byte) begin
				bytes_q   <= '0;
				lead_q    <= '0;
				pend_q    <= '0;
				u8_bad_q  <= 1'b0;
				await_q   <= 1'b0;
				gbk_bad_q <= 1'b0;
				dbl_q     <= '0;
				tot_q     <= '0;
			end else begin
				bytes_q   <= bytes_n;
				lead_q    <= lead_n;
				pend_q    <= pend_n;
				u8_bad_q  <= u8_bad_n;
				await_q   <= await_n;
				gbk_bad_q <= gbk_bad_n;
				dbl_q     <= dbl_n;
				tot_q     <= tot_n;
			end
		end
	end

	a_bytes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_q <= CW'(MAX_BYTES))
		else $error("byte count passed the examine limit");

	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		dbl_q <= tot_q && tot_q <= bytes_q)
		else $error("character counts out of order");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> bytes_q == CW'(0) && tot_q == CW'(0))
		else $error("state not cleared after final word");

endmodule

FILE: rtl/core/text_encoding_detector_core.sv
// Top level of the text encoding detector: config register, scanner, decision pipeline.
//
// Usage:
// Byte channel (byte_valid / byte_stall, data_byte, last_byte) carries one
// file's bytes in order; last_byte marks the final word of the file. Only the
// first MAX_BYTES bytes are examined, later ones only end the file.
// Code channel (code_valid / code_stall, encoding_code) returns one word per
// file: 0 UTF-8, 1 UTF-16LE, 2 UTF-16BE, 3 GBK, 4 system default.
// Throughput: one byte per cycle while byte_stall is low; the scanner updates its counters and flags
// in the cycle the byte is taken, so back-to-back files are fine too.
// Result path: the summary is captured in stage 1 on the edge that takes the final
// byte, stage 2 forms the products, the result register holds the compare/priority pick.
// The GBK share register sits at APB address 0 and is meant to be written
// only while no file is in flight.
// Reset clears all per-file state and the pipeline valids; the share register
// returns to 30 percent. While code_stall is high the result holds and the
// pipeline fills; byte_stall rises only once a final byte can no longer be
// captured, and non-final bytes are then held off as well.
`timescale 1ns / 1ps

module text_encoding_detector_core import ted_pkg::*; #(
	parameter int MAX_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        code_valid,
	input  logic        code_stall,
	output logic [2:0]  encoding_code,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(MAX_BYTES + 1);
	localparam int PW = CW + 8;

	logic [6:0]    share_q;
	logic          accept;
	ted_flags_t    scan_flags;
	logic [CW-1:0] scan_dbl, scan_tot;

	logic          valid_s1, valid_s2;
	ted_flags_t    flags_s1, flags_s2;
	logic [CW-1:0] dbl_s1, tot_s1;
	logic [PW-1:0] dbl_prod_s2, lim_prod_s2;
	logic [2:0]    code_q;
	logic          valid_q;
	logic          out_free, s2_free, s1_free;
	logic [2:0]    code_n;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {25'd0, share_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			share_q <= SHARE_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			share_q <= pwdata[6:0];
		end
	end

	// Pipeline flow control
	assign out_free   = !valid_q || !code_stall;
	assign s2_free    = !valid_s2 || out_free;
	assign s1_free    = !valid_s1 || s2_free;
	assign byte_stall = !s1_free;
	assign accept     = byte_valid && !byte_stall;

	ted_scan #(.MAX_BYTES(MAX_BYTES)) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.flags     (scan_flags),
		.dbl_count (scan_dbl),
		.tot_count (scan_tot)
	);

	// Stage 1: capture the file summary on its final word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= accept && last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && accept && last_byte) begin
			flags_s1 <= scan_flags;
			dbl_s1   <= scan_dbl;
			tot_s1   <= scan_tot;
		end
	end

	// Stage 2: form both sides of the share compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			flags_s2    <= flags_s1;
			dbl_prod_s2 <= PW'(dbl_s1) * PW'(PERCENT_SCALE);
			lim_prod_s2 <= PW'({1'b0, share_q} + 8'd1) * PW'(tot_s1);
		end
	end

	// Pick the code in priority order
	always_comb begin
		if (flags_s2.bom_utf8) begin
			code_n = CODE_UTF8;
		end else if (flags_s2.bom_le) begin
			code_n = CODE_UTF16LE;
		end else if (flags_s2.bom_be) begin
			code_n = CODE_UTF16BE;
		end else if (flags_s2.utf8_ok) begin
			code_n = CODE_UTF8;
		end else if (flags_s2.gbk_ok && dbl_prod_s2 >= lim_prod_s2) begin
			code_n = CODE_GBK;
		end else begin
			code_n = CODE_SYSTEM;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			code_q <= code_n;
		end
	end

	assign code_valid    = valid_q;
	assign encoding_code = code_q;

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> encoding_code <= CODE_SYSTEM)
		else $error("encoding code out of range");

	a_final_captured: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> valid_s1)
		else $error("final word not captured");

	a_s2_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && valid_q && code_stall |=> valid_s2 && $stable(dbl_prod_s2))
		else $error("stage 2 lost while result stalled");

endmodule
